/* hw/rtl/cubic_bezier_forward_difference_core_defines.svh */
`ifndef CUBIC_BEZIER_FORWARD_DIFFERENCE_CORE_DEFINES_SVH
`define CUBIC_BEZIER_FORWARD_DIFFERENCE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CBFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CBFD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/cbfd_pkg.sv */
`default_nettype none

package cbfd_pkg;

  localparam int COORD_W       = 32;
  localparam int ACC_W         = 64;
  localparam int ACC_FRAC_BITS = 40;
  localparam int SHIFT_UP      = ACC_FRAC_BITS - 16;
  localparam int MAX_SEGMENTS  = 64;
  localparam int SEG_W         = 7;
  localparam int IDX_W         = 6;
  // bezier coefficients need four guard bits over a coordinate
  localparam int CO_W          = COORD_W + 4;
  localparam int NUM_W         = 48;
  localparam int NSQ_W         = 13;
  localparam int DEN_W         = 19;
  localparam int DVD_W         = NUM_W + SHIFT_UP;
  localparam int DIV_RADIX     = 4;
  localparam int DIV_STEPS     = DVD_W / DIV_RADIX;

  localparam logic [SEG_W-1:0] SEG_RESET = 7'd8;
  localparam logic [SEG_W-1:0] SEG_MIN   = 7'd2;
  localparam logic [SEG_W-1:0] SEG_MAX   = 7'(MAX_SEGMENTS);

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    coord_t p0_x;
    coord_t p0_y;
    coord_t p0_z;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p1_z;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p2_z;
    coord_t p3_x;
    coord_t p3_y;
    coord_t p3_z;
  } curve_t;

  typedef struct packed {
    coord_t             point_x;
    coord_t             point_y;
    coord_t             point_z;
    logic [IDX_W-1:0]   point_index;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic start;
    logic step;
  } lane_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/cbfd_if.sv */
`default_nettype none

interface cbfd_curve_if;
  logic              valid;
  logic              ready;
  cbfd_pkg::curve_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cbfd_point_if;
  logic              valid;
  logic              ready;
  cbfd_pkg::point_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cbfd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cbfd_pkg::SEG_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cbfd_div.sv */
`default_nettype none

// restoring divider, four quotient bits per cycle, quotient kept modulo 2^64
module cbfd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cbfd_pkg::DVD_W-1:0]    dividend_i,
  input  logic [cbfd_pkg::DEN_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [cbfd_pkg::ACC_W-1:0]    quot_o
);

  localparam int CNT_W = $clog2(cbfd_pkg::DIV_STEPS);
  localparam int REM_W = cbfd_pkg::DEN_W + 1;

  logic                          busy_q;
  logic                          done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [cbfd_pkg::DEN_W-1:0]    rem_q, rem_d;
  logic [cbfd_pkg::DVD_W-1:0]    dvd_q;
  logic [cbfd_pkg::ACC_W-1:0]    quo_q, quo_d;

  always_comb begin
    logic [REM_W-1:0] part;
    rem_d = rem_q;
    quo_d = quo_q;
    part  = '0;
    for (int k = 0; k < cbfd_pkg::DIV_RADIX; k++) begin
      part = {rem_d, dvd_q[cbfd_pkg::DVD_W-1-k]};
      if (part >= {1'b0, divisor_i}) begin
        part  = part - {1'b0, divisor_i};
        quo_d = {quo_d[cbfd_pkg::ACC_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[cbfd_pkg::ACC_W-2:0], 1'b0};
      end
      rem_d = part[cbfd_pkg::DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(cbfd_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= '0;
      dvd_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      dvd_q <= dvd_q << cbfd_pkg::DIV_RADIX;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/cbfd_lane.sv */
`default_nettype none

// one axis: coefficient setup, difference division, forward-difference stepping
module cbfd_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cbfd_pkg::lane_ctrl_t          ctrl_i,
  input  cbfd_pkg::coord_t              p0_i,
  input  cbfd_pkg::coord_t              p1_i,
  input  cbfd_pkg::coord_t              p2_i,
  input  cbfd_pkg::coord_t              p3_i,
  input  logic [cbfd_pkg::SEG_W-1:0]    n_i,
  input  logic [cbfd_pkg::NSQ_W-1:0]    nsq_i,
  input  logic [cbfd_pkg::DEN_W-1:0]    den_i,
  output logic                          ready_o,
  output cbfd_pkg::coord_t              coord_o
);

  localparam int CO_W   = cbfd_pkg::CO_W;
  localparam int NUM_W  = cbfd_pkg::NUM_W;
  localparam int ACC_W  = cbfd_pkg::ACC_W;
  localparam int BN_W   = CO_W + cbfd_pkg::SEG_W + 1;
  localparam int CN_W   = CO_W + cbfd_pkg::NSQ_W + 1;
  localparam int SAT_LO = cbfd_pkg::SHIFT_UP + cbfd_pkg::COORD_W - 1;
  localparam int EXT_W  = ACC_W - cbfd_pkg::SHIFT_UP - cbfd_pkg::COORD_W;

  localparam logic [cbfd_pkg::SHIFT_UP-1:0] RND_HALF =
    {1'b1, {(cbfd_pkg::SHIFT_UP-1){1'b0}}};

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_PROD = 2'd1;
  localparam logic [1:0] L_NUM  = 2'd2;
  localparam logic [1:0] L_DIV  = 2'd3;

  localparam logic [1:0] SEL_D1   = 2'd0;
  localparam logic [1:0] SEL_D2   = 2'd1;
  localparam logic [1:0] SEL_LAST = 2'd2;

  logic [1:0]              lstate_q;
  logic [1:0]              sel_q;
  logic                    div_start_q;
  logic                    ready_q;

  logic signed [CO_W-1:0]  a_d, b_d, c_d;
  logic signed [CO_W-1:0]  a_q, b_q, c_q;
  logic signed [BN_W-1:0]  bn_prod;
  logic signed [CN_W-1:0]  cn_prod;
  logic signed [NUM_W-1:0] bn_q, cn_q;
  logic signed [NUM_W-1:0] a_n, a6;
  logic signed [NUM_W-1:0] num_q [3];
  logic signed [NUM_W-1:0] num_sel;
  logic                    div_neg;
  logic [NUM_W-1:0]        div_mag;
  logic [cbfd_pkg::DVD_W-1:0] div_dvd;
  logic                    div_done;
  logic [ACC_W-1:0]        div_quot;
  logic [ACC_W-1:0]        div_res;

  // pos_q carries the output rounding offset, so one add gives the rounded point
  logic [ACC_W-1:0]        pos_q, pos_d;
  logic [ACC_W-1:0]        dif1_q, dif2_q, dif3_q;
  logic [ACC_W-SAT_LO-1:0] sat_hi;

  always_comb begin
    logic signed [CO_W-1:0] q0, q1, q2, q3, d12, s, t;
    q0  = CO_W'(p0_i);
    q1  = CO_W'(p1_i);
    q2  = CO_W'(p2_i);
    q3  = CO_W'(p3_i);
    d12 = q1 - q2;
    s   = q0 - (q1 <<< 1) + q2;
    t   = q1 - q0;
    a_d = q3 - q0 + (d12 <<< 1) + d12;
    b_d = (s <<< 1) + s;
    c_d = (t <<< 1) + t;
  end

  assign bn_prod = b_q * $signed({1'b0, n_i});
  assign cn_prod = c_q * $signed({1'b0, nsq_i});

  assign a_n = NUM_W'(a_q);
  assign a6  = (a_n <<< 2) + (a_n <<< 1);

  // dividend is |num| * 2^shift + floor(den / 2), which rounds ties away from zero
  assign num_sel = num_q[sel_q];
  assign div_neg = num_sel[NUM_W-1];
  assign div_mag = div_neg ? -num_sel : num_sel;
  assign div_dvd = {div_mag, cbfd_pkg::SHIFT_UP'(den_i >> 1)};
  assign div_res = div_neg ? -div_quot : div_quot;

  cbfd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dvd),
    .divisor_i  (den_i),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lstate_q    <= L_IDLE;
      sel_q       <= SEL_D1;
      div_start_q <= 1'b0;
      ready_q     <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      ready_q     <= 1'b0;
      unique case (lstate_q)
        L_IDLE: begin
          if (ctrl_i.start) lstate_q <= L_PROD;
        end
        L_PROD: begin
          lstate_q <= L_NUM;
        end
        L_NUM: begin
          lstate_q    <= L_DIV;
          sel_q       <= SEL_D1;
          div_start_q <= 1'b1;
        end
        L_DIV: begin
          if (div_done) begin
            if (sel_q == SEL_LAST) begin
              lstate_q <= L_IDLE;
              ready_q  <= 1'b1;
            end else begin
              sel_q       <= sel_q + 2'd1;
              div_start_q <= 1'b1;
            end
          end
        end
        default: lstate_q <= L_IDLE;
      endcase
    end
  end

  assign pos_d = pos_q + dif1_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && (lstate_q == L_IDLE)) begin
      a_q   <= a_d;
      b_q   <= b_d;
      c_q   <= c_d;
      pos_q <= {{EXT_W{p0_i[cbfd_pkg::COORD_W-1]}}, p0_i, RND_HALF};
    end
    if (lstate_q == L_PROD) begin
      bn_q <= NUM_W'(bn_prod);
      cn_q <= NUM_W'(cn_prod);
    end
    if (lstate_q == L_NUM) begin
      num_q[0] <= a_n + bn_q + cn_q;
      num_q[1] <= a6 + (bn_q <<< 1);
      num_q[2] <= a6;
    end
    if ((lstate_q == L_DIV) && div_done) begin
      case (sel_q)
        SEL_D1:   dif1_q <= div_res;
        SEL_D2:   dif2_q <= div_res;
        default:  dif3_q <= div_res;
      endcase
    end
    if (ctrl_i.step) begin
      pos_q  <= pos_d;
      dif1_q <= dif1_q + dif2_q;
      dif2_q <= dif2_q + dif3_q;
    end
  end

  assign sat_hi = pos_d[ACC_W-1:SAT_LO];

  always_comb begin
    if ((&sat_hi) || !(|sat_hi)) begin
      coord_o = pos_d[SAT_LO:cbfd_pkg::SHIFT_UP];
    end else if (pos_d[ACC_W-1]) begin
      coord_o = cbfd_pkg::COORD_MIN;
    end else begin
      coord_o = cbfd_pkg::COORD_MAX;
    end
  end

  assign ready_o = ready_q;

endmodule

`default_nettype wire

/* hw/rtl/cubic_bezier_forward_difference_core.sv */
// Cubic Bezier evaluator by forward differencing.
// curve_i takes one curve (four 3D control points, signed Q16.16) per transaction.
// point_o returns the segment_count - 1 interior points in order, each with its
// step number; last_point marks the final point of the curve.
// cfg_i writes segment_count (2..64, reset 8; values outside are clamped).
// Three axis lanes run side by side; the output register merges their points.
// The setup is set by the three difference divisions per axis in a lane's
// radix-16 divider. After that one point leaves per cycle while point_o does
// not stall.
// curve_i.ready rises again once the last point sits in the output register, so
// the next curve's setup overlaps the wait for that point to be taken.
// A stall on point_o holds the output register and freezes the lanes' stepping.
// After reset and after a cfg_i write, curve_i.ready stays low while the step
// constants settle. Reset clears the control state and the output valid.
`default_nettype none

module cubic_bezier_forward_difference_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  cbfd_curve_if.sink          curve_i,
  cbfd_point_if.source        point_o,
  cbfd_cfg_if.sink            cfg_i
);

  localparam int SEG_W = cbfd_pkg::SEG_W;
  localparam int IDX_W = cbfd_pkg::IDX_W;
  localparam int NSQ_W = cbfd_pkg::NSQ_W;
  localparam int DEN_W = cbfd_pkg::DEN_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;

  localparam logic [1:0] SETTLE = 2'd3;

  logic [1:0]              state_q;
  logic                    start_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    out_valid_q;
  cbfd_pkg::point_t        out_q;
  cbfd_pkg::curve_t        cur_q;
  logic [SEG_W-1:0]        seg_q;
  logic [1:0]              settle_q;
  logic [SEG_W-1:0]        n_clamp, n_q;
  logic [2*SEG_W-1:0]      nsq_full;
  logic [NSQ_W-1:0]        nsq_q;
  logic [NSQ_W+SEG_W-1:0]  den_full;
  logic [DEN_W-1:0]        den_q;

  logic                    in_ready;
  logic                    in_acc;
  logic                    cfg_acc;
  logic                    step;
  logic                    last;
  logic                    setup_done;
  cbfd_pkg::lane_ctrl_t    lane_ctrl;
  logic [2:0]              lane_rdy;
  cbfd_pkg::coord_t        lane_coord [3];
  cbfd_pkg::coord_t        lane_p [3][4];

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;

  assign n_clamp = (seg_q < cbfd_pkg::SEG_MIN) ? cbfd_pkg::SEG_MIN :
                   (seg_q > cbfd_pkg::SEG_MAX) ? cbfd_pkg::SEG_MAX : seg_q;
  assign nsq_full = n_q * n_q;
  assign den_full = nsq_q * n_q;

  always_ff @(posedge clk_i) begin
    n_q   <= n_clamp;
    nsq_q <= NSQ_W'(nsq_full);
    den_q <= DEN_W'(den_full);
  end

  assign in_ready      = (state_q == S_IDLE) && (settle_q == 2'd0) && !cfg_i.valid;
  assign curve_i.ready = in_ready;
  assign in_acc        = curve_i.valid && in_ready;

  assign step       = (state_q == S_RUN) && (!out_valid_q || point_o.ready);
  assign last       = (idx_q == IDX_W'(n_q - SEG_W'(1)));
  assign setup_done = &lane_rdy;

  assign lane_ctrl.start = start_q;
  assign lane_ctrl.step  = step;

  assign lane_p[0][0] = cur_q.p0_x;
  assign lane_p[0][1] = cur_q.p1_x;
  assign lane_p[0][2] = cur_q.p2_x;
  assign lane_p[0][3] = cur_q.p3_x;
  assign lane_p[1][0] = cur_q.p0_y;
  assign lane_p[1][1] = cur_q.p1_y;
  assign lane_p[1][2] = cur_q.p2_y;
  assign lane_p[1][3] = cur_q.p3_y;
  assign lane_p[2][0] = cur_q.p0_z;
  assign lane_p[2][1] = cur_q.p1_z;
  assign lane_p[2][2] = cur_q.p2_z;
  assign lane_p[2][3] = cur_q.p3_z;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    cbfd_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .p0_i    (lane_p[g][0]),
      .p1_i    (lane_p[g][1]),
      .p2_i    (lane_p[g][2]),
      .p3_i    (lane_p[g][3]),
      .n_i     (n_q),
      .nsq_i   (nsq_q),
      .den_i   (den_q),
      .ready_o (lane_rdy[g]),
      .coord_o (lane_coord[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      idx_q       <= IDX_W'(1);
      out_valid_q <= 1'b0;
      seg_q       <= cbfd_pkg::SEG_RESET;
      settle_q    <= SETTLE;
    end else begin
      start_q <= 1'b0;
      if (cfg_acc) begin
        seg_q    <= cfg_i.data;
        settle_q <= SETTLE;
      end else if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end

      if (step) begin
        out_valid_q <= 1'b1;
      end else if (point_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_SETUP;
            start_q <= 1'b1;
          end
        end
        S_SETUP: begin
          if (setup_done) begin
            state_q <= S_RUN;
            idx_q   <= IDX_W'(1);
          end
        end
        S_RUN: begin
          if (step) begin
            idx_q <= idx_q + IDX_W'(1);
            if (last) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q <= curve_i.data;
    end
    if (step) begin
      out_q.point_x     <= lane_coord[0];
      out_q.point_y     <= lane_coord[1];
      out_q.point_z     <= lane_coord[2];
      out_q.point_index <= idx_q;
      out_q.last_point  <= last;
    end
  end

  assign point_o.valid = out_valid_q;
  assign point_o.data  = out_q;

endmodule

`default_nettype wire

/* hw/rtl/cbfd_checker.sv */
`default_nettype none

`include "cubic_bezier_forward_difference_core_defines.svh"

module cbfd_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  cbfd_pkg::point_t  point_i
);

  localparam int IDX_W = cbfd_pkg::IDX_W;

  logic [IDX_W-1:0] exp_q;
  logic             mid_q;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // expected step number of the next point, and whether a curve is still open
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= IDX_W'(1);
      mid_q <= 1'b0;
    end else begin
      if (out_acc) begin
        exp_q <= point_i.last_point ? IDX_W'(1) : point_i.point_index + IDX_W'(1);
      end
      if (in_acc) begin
        mid_q <= 1'b1;
      end else if (out_valid_i && point_i.last_point) begin
        mid_q <= 1'b0;
      end
    end
  end

  `CBFD_ASSERT_NXT(a_out_valid_hold, out_valid_i && !out_ready_i, out_valid_i, "point dropped while stalled")
  `CBFD_ASSERT_NXT(a_out_data_hold, out_valid_i && !out_ready_i, $stable(point_i), "point changed while stalled")
  `CBFD_ASSERT_IMP(a_index_seq, out_valid_i, point_i.point_index == exp_q, "point index out of sequence")
  `CBFD_ASSERT_IMP(a_no_overlap, in_acc, !mid_q || (out_valid_i && point_i.last_point), "curve taken before last point")

endmodule

bind cubic_bezier_forward_difference_core cbfd_checker u_cbfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (curve_i.valid),
  .in_ready_i  (curve_i.ready),
  .out_valid_i (point_o.valid),
  .out_ready_i (point_o.ready),
  .point_i     (point_o.data)
);

`default_nettype wire
